>>> rtl/ctpd_pkg.sv
`timescale 1ns / 1ps

package ctpd_pkg;

	localparam int ACTION_W = 2;
	localparam int TS_W     = 32;
	localparam int RATE_W   = 16;
	localparam int TOOTH_W  = 5;
	localparam int STEP_W   = 5;
	localparam int REVS_W   = 16;
	localparam int ANGLE_W  = 10;
	localparam int OFFSET_W = 10;
	localparam int DEG_W    = 9;
	localparam int PROD_W   = TS_W + RATE_W;
	localparam int FRAC_W   = 15;
	localparam int SUM_W    = 12;

	localparam logic [TOOTH_W-1:0] TOOTH_COUNT = 5'd24;
	localparam logic [TOOTH_W-1:0] WAIT_COUNT  = 5'd25;
	localparam logic [STEP_W-1:0]  FIRST_STEP  = 5'd15;
	localparam logic [ANGLE_W-1:0] INTERP_MAX  = 10'd719;
	localparam logic [ANGLE_W-1:0] HALF_DEG    = 10'd360;
	localparam logic signed [SUM_W-1:0] CYCLE_DEG   = 12'sd720;
	localparam logic signed [SUM_W-1:0] TWO_CYCLES  = 12'sd1440;

	localparam logic [ACTION_W-1:0] ACT_TOOTH = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CAM   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

	// angle of tooth n (1..24) after the cam mark; zero outside that range
	function automatic logic [DEG_W-1:0] tooth_angle(input logic [TOOTH_W-1:0] tooth);
		logic [DEG_W-1:0] deg;
		case (tooth)
			5'd1:    deg = 9'd12;
			5'd2:    deg = 9'd18;
			5'd3:    deg = 9'd33;
			5'd4:    deg = 9'd48;
			5'd5:    deg = 9'd63;
			5'd6:    deg = 9'd78;
			5'd7:    deg = 9'd102;
			5'd8:    deg = 9'd108;
			5'd9:    deg = 9'd123;
			5'd10:   deg = 9'd138;
			5'd11:   deg = 9'd162;
			5'd12:   deg = 9'd177;
			5'd13:   deg = 9'd183;
			5'd14:   deg = 9'd198;
			5'd15:   deg = 9'd222;
			5'd16:   deg = 9'd237;
			5'd17:   deg = 9'd252;
			5'd18:   deg = 9'd258;
			5'd19:   deg = 9'd282;
			5'd20:   deg = 9'd288;
			5'd21:   deg = 9'd312;
			5'd22:   deg = 9'd327;
			5'd23:   deg = 9'd342;
			5'd24:   deg = 9'd357;
			default: deg = 9'd0;
		endcase
		return deg;
	endfunction

	typedef struct packed {
		logic               in_sync;
		logic [TOOTH_W-1:0] tooth_number;
		logic [STEP_W-1:0]  tooth_step_deg;
		logic               second_revolution;
		logic [TS_W-1:0]    revolution_period_us;
		logic [REVS_W-1:0]  revolution_count;
	} status_t;

endpackage

>>> rtl/ctpd_in_if.sv
`timescale 1ns / 1ps

interface ctpd_in_if;
	logic                            valid;
	logic                            ready;
	logic [ctpd_pkg::ACTION_W-1:0]   action;
	logic [ctpd_pkg::TS_W-1:0]       timestamp_us;
	logic [ctpd_pkg::RATE_W-1:0]     deg_per_us_q15;

	modport source (output valid, output action, output timestamp_us,
		output deg_per_us_q15, input ready);
	modport sink (input valid, input action, input timestamp_us,
		input deg_per_us_q15, output ready);
endinterface

>>> rtl/ctpd_out_if.sv
`timescale 1ns / 1ps

interface ctpd_out_if;
	logic                            valid;
	logic                            ready;
	logic                            in_sync;
	logic [ctpd_pkg::TOOTH_W-1:0]    tooth_number;
	logic [ctpd_pkg::STEP_W-1:0]     tooth_step_deg;
	logic                            second_revolution;
	logic [ctpd_pkg::TS_W-1:0]       revolution_period_us;
	logic [ctpd_pkg::REVS_W-1:0]     revolution_count;
	logic [ctpd_pkg::ANGLE_W-1:0]    crank_angle_deg;

	modport source (output valid, output in_sync, output tooth_number,
		output tooth_step_deg, output second_revolution, output revolution_period_us,
		output revolution_count, output crank_angle_deg, input ready);
	modport sink (input valid, input in_sync, input tooth_number,
		input tooth_step_deg, input second_revolution, input revolution_period_us,
		input revolution_count, input crank_angle_deg, output ready);
endinterface

>>> rtl/crank_tooth_position_decoder.sv
// A request passes through the input register, the multiply stage and the result register.
// Throughput: one request per cycle while results.ready does not stall the pipeline;
// each stage holds while the stage after it is full and cannot advance.
// Decoder state updates when a request leaves the input register, so requests see it in order.
// Reset (arst_n low, asynchronous): pipeline empty, tooth count 25 (waiting for cam),
// no sync, first half, times and revolution count zero, step 15, angle offset zero.
`timescale 1ns / 1ps

module crank_tooth_position_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ctpd_in_if.sink                              events,
	ctpd_out_if.source                           results,
	input  logic                                 angle_offset_we,
	input  logic signed [ctpd_pkg::OFFSET_W-1:0] angle_offset_wdata
);
	import ctpd_pkg::*;

	// configuration and decoder state
	logic signed [OFFSET_W-1:0] angle_offset_q;
	logic [TOOTH_W-1:0]         tooth_q, tooth_d;
	logic                       half_q, half_d;
	logic                       sync_q, sync_d;
	logic [TS_W-1:0]            last_time_q, last_time_d;
	logic [TS_W-1:0]            one_time_q, one_time_d;
	logic [TS_W-1:0]            prev_one_q, prev_one_d;
	logic [REVS_W-1:0]          revs_q, revs_d;
	logic [STEP_W-1:0]          step_q, step_d;

	// stage 1: input register
	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [TS_W-1:0]     ts_s1;
	logic [RATE_W-1:0]   rate_s1;

	// stage 2: product and snapshot
	logic                       valid_s2;
	logic                       query_s2;
	logic [PROD_W-FRAC_W-1:0]   interp_s2;
	logic [ANGLE_W-1:0]         base_s2;
	status_t                    status_s2;

	// result register
	logic               out_valid_q;
	status_t            status_q;
	logic [ANGLE_W-1:0] angle_q;

	logic ready_out, ready_s2, ready_s1, adv_s1, adv_s2;

	assign ready_out    = !out_valid_q || results.ready;
	assign ready_s2     = !valid_s2 || ready_out;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign events.ready = ready_s1;
	assign adv_s1       = valid_s1 && ready_s2;
	assign adv_s2       = valid_s2 && ready_out;

	// next decoder state for the request in stage 1
	always_comb begin
		tooth_d     = tooth_q;
		half_d      = half_q;
		sync_d      = sync_q;
		last_time_d = last_time_q;
		one_time_d  = one_time_q;
		prev_one_d  = prev_one_q;
		revs_d      = revs_q;
		step_d      = step_q;
		case (action_s1)
			ACT_TOOTH: begin
				if (tooth_q >= WAIT_COUNT) begin
					sync_d = 1'b0;
				end else if (tooth_q == '0) begin
					tooth_d     = 5'd1;
					prev_one_d  = one_time_q;
					one_time_d  = ts_s1;
					half_d      = !half_q;
					sync_d      = 1'b1;
					revs_d      = revs_q + 1'b1;
					step_d      = FIRST_STEP;
					last_time_d = ts_s1;
				end else if (tooth_q >= TOOTH_COUNT) begin
					// ran past the last tooth without a cam: lose sync
					tooth_d = WAIT_COUNT;
					sync_d  = 1'b0;
				end else begin
					tooth_d     = tooth_q + 1'b1;
					step_d      = STEP_W'(tooth_angle(tooth_q + 1'b1) - tooth_angle(tooth_q));
					last_time_d = ts_s1;
				end
			end
			ACT_CAM: begin
				tooth_d = '0;
				half_d  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	logic [TS_W-1:0]    elapsed;
	logic [PROD_W-1:0]  product;
	logic [ANGLE_W-1:0] base_angle;

	assign elapsed    = ts_s1 - last_time_q;
	assign product    = PROD_W'(elapsed) * PROD_W'(rate_s1);
	assign base_angle = ANGLE_W'(tooth_angle(tooth_q)) + (half_q ? HALF_DEG : '0);

	// stage 2: saturate, add offset, wrap into the 720-degree cycle
	logic [ANGLE_W-1:0]       interp_sat;
	logic signed [SUM_W-1:0]  sum, wrapped;

	assign interp_sat = (interp_s2 > (PROD_W-FRAC_W)'(INTERP_MAX)) ? INTERP_MAX
		: interp_s2[ANGLE_W-1:0];

	always_comb begin
		sum = $signed({2'b00, base_s2}) + SUM_W'(angle_offset_q)
			+ $signed({2'b00, interp_sat});
		if (sum < 0) begin
			wrapped = sum + CYCLE_DEG;
		end else if (sum >= TWO_CYCLES) begin
			wrapped = sum - TWO_CYCLES;
		end else if (sum >= CYCLE_DEG) begin
			wrapped = sum - CYCLE_DEG;
		end else begin
			wrapped = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_offset_q <= '0;
			tooth_q        <= WAIT_COUNT;
			half_q         <= 1'b0;
			sync_q         <= 1'b0;
			last_time_q    <= '0;
			one_time_q     <= '0;
			prev_one_q     <= '0;
			revs_q         <= '0;
			step_q         <= FIRST_STEP;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (angle_offset_we) begin
				angle_offset_q <= angle_offset_wdata;
			end
			if (adv_s1) begin
				tooth_q     <= tooth_d;
				half_q      <= half_d;
				sync_q      <= sync_d;
				last_time_q <= last_time_d;
				one_time_q  <= one_time_d;
				prev_one_q  <= prev_one_d;
				revs_q      <= revs_d;
				step_q      <= step_d;
			end
			if (ready_s1) begin
				valid_s1 <= events.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && events.valid) begin
			action_s1 <= events.action;
			ts_s1     <= events.timestamp_us;
			rate_s1   <= events.deg_per_us_q15;
		end
		if (adv_s1) begin
			query_s2                       <= (action_s1 == ACT_QUERY);
			interp_s2                      <= product[PROD_W-1:FRAC_W];
			base_s2                        <= base_angle;
			status_s2.in_sync              <= sync_d;
			status_s2.tooth_number         <= tooth_d;
			status_s2.tooth_step_deg       <= step_d;
			status_s2.second_revolution    <= half_d;
			status_s2.revolution_period_us <= one_time_d - prev_one_d;
			status_s2.revolution_count     <= revs_d;
		end
		if (adv_s2) begin
			status_q <= status_s2;
			angle_q  <= query_s2 ? wrapped[ANGLE_W-1:0] : '0;
		end
	end

	assign results.valid                = out_valid_q;
	assign results.in_sync              = status_q.in_sync;
	assign results.tooth_number         = status_q.tooth_number;
	assign results.tooth_step_deg       = status_q.tooth_step_deg;
	assign results.second_revolution    = status_q.second_revolution;
	assign results.revolution_period_us = status_q.revolution_period_us;
	assign results.revolution_count     = status_q.revolution_count;
	assign results.crank_angle_deg      = angle_q;

endmodule
